[rtl/clp_pkg.sv]
`default_nettype none

package clp_pkg;

	localparam int PIX_W        = 8;
	localparam int SAMPLE_W     = 9;
	localparam int WEIGHT_W     = 18;
	localparam int LINE_WIDTH_W = 13;
	localparam int CFG_INDEX_W  = 3;
	localparam int CFG_DATA_W   = 18;

	// Configuration register map
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_DIRECTION       = 3'd0,
		REG_LINE_WIDTH      = 3'd1,
		REG_WEIGHT_UP_LEFT  = 3'd2,
		REG_WEIGHT_UP       = 3'd3,
		REG_WEIGHT_UP_RIGHT = 3'd4,
		REG_WEIGHT_LEFT     = 3'd5
	} cfg_reg_t;

	localparam logic DIR_ENCODE = 1'b0;
	localparam logic DIR_DECODE = 1'b1;

	localparam logic [LINE_WIDTH_W-1:0]    LINE_WIDTH_RESET = 13'd4096;
	localparam logic signed [WEIGHT_W-1:0] WEIGHT_RESET     = 18'sd4096;

	// Predictor weights
	typedef struct packed {
		logic signed [WEIGHT_W-1:0] up_left;
		logic signed [WEIGHT_W-1:0] up;
		logic signed [WEIGHT_W-1:0] up_right;
		logic signed [WEIGHT_W-1:0] left;
	} weights_t;

	// Position flags of one pixel in the raster
	typedef struct packed {
		logic first_row;
		logic col_zero;
		logic last;
	} pos_t;

endpackage

`default_nettype wire

[rtl/clp_ram.sv]
`default_nettype none

module clp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[rtl/clp_col.sv]
`default_nettype none

module clp_col
	import clp_pkg::*;
#(
	parameter int MAX_WIDTH = 4096,
	parameter int COL_W     = $clog2(MAX_WIDTH),
	parameter int CMP_W     = (COL_W + 1 > LINE_WIDTH_W) ? COL_W + 1 : LINE_WIDTH_W
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    accept,
	input  wire logic                    frame_start,
	input  wire logic [LINE_WIDTH_W-1:0] line_width,
	input  wire logic                    pend1_valid,
	input  wire logic [COL_W-1:0]        pend1_col,
	input  wire logic                    pend2_valid,
	input  wire logic [COL_W-1:0]        pend2_col,
	output logic      [COL_W-1:0]        col,
	output logic      [COL_W-1:0]        ur_addr,
	output pos_t                         pos,
	output logic                         hazard
);

	logic [COL_W-1:0] col_q;
	logic             first_q;
	logic [CMP_W-1:0] lw_ext;
	logic [CMP_W-1:0] eff_width;
	logic [CMP_W-1:0] next_col;
	logic             hit1;
	logic             hit2;

	// Clamp the row length to 1..MAX_WIDTH
	always_comb begin
		lw_ext = CMP_W'(line_width);
		if (lw_ext == '0) begin
			eff_width = CMP_W'(1);
		end else if (lw_ext > CMP_W'(MAX_WIDTH)) begin
			eff_width = CMP_W'(MAX_WIDTH);
		end else begin
			eff_width = lw_ext;
		end
	end

	// Position of the word at the input
	always_comb begin
		col           = frame_start ? '0 : col_q;
		pos.first_row = frame_start | first_q;
		pos.col_zero  = (col == '0);
		next_col      = CMP_W'(col) + CMP_W'(1);
		pos.last      = (next_col >= eff_width);
		ur_addr       = pos.last ? col : next_col[COL_W-1:0];
	end

	// Hold the word while an older pixel still has to write an entry it reads
	always_comb begin
		hit1   = pend1_valid && (pend1_col == col || (!pos.last && pend1_col == ur_addr));
		hit2   = pend2_valid && (pend2_col == col || (!pos.last && pend2_col == ur_addr));
		hazard = !pos.first_row && (hit1 || hit2);
	end

	// Advance the column and row on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			first_q <= 1'b1;
		end else if (accept) begin
			if (pos.last) begin
				col_q   <= '0;
				first_q <= 1'b0;
			end else begin
				col_q   <= next_col[COL_W-1:0];
				first_q <= pos.first_row;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/clp_dp.sv]
`default_nettype none

module clp_dp
	import clp_pkg::*;
#(
	parameter int FRAC_BITS = 14
) (
	input  wire logic                       clk,
	input  wire logic                       s1_adv,
	input  wire logic                       s2_adv,
	input  wire pos_t                       pos_s1,
	input  wire pos_t                       pos_s2,
	input  wire logic [PIX_W-1:0]           up_data,
	input  wire logic [PIX_W-1:0]           ur_data,
	input  wire weights_t                   weights,
	input  wire logic                       direction,
	input  wire logic signed [SAMPLE_W-1:0] sample_s2,
	output logic      [PIX_W-1:0]           pix,
	output logic signed [SAMPLE_W-1:0]      res,
	output logic      [PIX_W-1:0]           pred
);

	localparam int PROD_W = PIX_W + 1 + WEIGHT_W;
	localparam int PART_W = PROD_W + 2;
	localparam int SUM_W  = PART_W + 1;
	localparam int Q_W    = SUM_W - 1 - FRAC_BITS;
	localparam logic [SUM_W-1:0] HALF = SUM_W'(1 << (FRAC_BITS - 1));

	logic [PIX_W-1:0]         ul_q;
	logic [PIX_W-1:0]         left_q;
	logic signed [PART_W-1:0] partial_s2;

	logic [PIX_W-1:0]         ul_n;
	logic [PIX_W-1:0]         u_n;
	logic [PIX_W-1:0]         ur_n;
	logic [PIX_W-1:0]         l_n;
	logic signed [PROD_W-1:0] prod_ul;
	logic signed [PROD_W-1:0] prod_u;
	logic signed [PROD_W-1:0] prod_ur;
	logic signed [PROD_W-1:0] prod_l;
	logic signed [PART_W-1:0] partial;
	logic signed [SUM_W-1:0]  sum;
	logic [SUM_W-1:0]         rnd;
	logic [Q_W-1:0]           q;
	logic signed [SAMPLE_W:0] dec;

	// Upper neighbors: three products summed ahead of the left-pixel loop
	always_comb begin
		ul_n    = (pos_s1.first_row || pos_s1.col_zero) ? '0 : ul_q;
		u_n     = pos_s1.first_row ? '0 : up_data;
		ur_n    = (pos_s1.first_row || pos_s1.last) ? '0 : ur_data;
		prod_ul = $signed({1'b0, ul_n}) * $signed(weights.up_left);
		prod_u  = $signed({1'b0, u_n}) * $signed(weights.up);
		prod_ur = $signed({1'b0, ur_n}) * $signed(weights.up_right);
		partial = PART_W'(prod_ul) + PART_W'(prod_u) + PART_W'(prod_ur);
	end

	// Upper-left of the next pixel is the up of this one
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			partial_s2 <= partial;
			ul_q       <= up_data;
		end
	end

	// Left term, rounding and saturation
	always_comb begin
		l_n    = pos_s2.col_zero ? '0 : left_q;
		prod_l = $signed({1'b0, l_n}) * $signed(weights.left);
		sum    = SUM_W'(partial_s2) + SUM_W'(prod_l);
		rnd    = $unsigned(sum) + HALF;
		q      = rnd[SUM_W-2:FRAC_BITS];
		if (sum <= 0) begin
			pred = '0;
		end else if (q > Q_W'(255)) begin
			pred = 8'd255;
		end else begin
			pred = q[PIX_W-1:0];
		end
	end

	// Residual or reconstructed pixel
	always_comb begin
		dec = $signed({2'b00, pred}) + $signed({sample_s2[SAMPLE_W-1], sample_s2});
		if (direction == DIR_ENCODE) begin
			pix = sample_s2[SAMPLE_W-1] ? '0 : sample_s2[PIX_W-1:0];
			res = $signed({1'b0, pix}) - $signed({1'b0, pred});
		end else begin
			if (dec < 0) begin
				pix = '0;
			end else if (dec > 255) begin
				pix = 8'd255;
			end else begin
				pix = dec[PIX_W-1:0];
			end
			res = $signed({1'b0, pix});
		end
	end

	// Close the left-pixel loop
	always_ff @(posedge clk) begin
		if (s2_adv) begin
			left_q <= pix;
		end
	end

endmodule

`default_nettype wire

[rtl/causal_linear_pixel_predictor.sv]
// Causal four-neighbor linear pixel predictor for an 8-bit grayscale raster.
// Input channel (in_valid/in_stall): one word per pixel, sample plus
// frame_start, which restarts row and column. Output channel
// (out_valid/out_stall): result (residual or reconstructed pixel) and the
// prediction used. Configuration is a plain write port, written while idle.
// Throughput: one pixel per clock unless the output stalls or a line-store
// hazard holds the input. The left-pixel feedback closes through the left
// multiply, rounding and saturation. Two copies of the line store give the up
// and up-right reads of a pixel in the same cycle. A pixel whose line-store
// entries are still being written by one of the two pixels ahead of it is
// held at the input until they are written; this happens only for rows of
// three pixels or fewer. Words pass s1, s2 and the output register (out_valid).
// Reset: row and column go to the top-left pixel, registers to their defaults;
// the line store is not cleared, as the first row never reads it.
// A stalled output keeps its word in the output register; the words in the
// two stages behind it hold, then in_stall rises.
`default_nettype none

module causal_linear_pixel_predictor
	import clp_pkg::*;
#(
	parameter int MAX_WIDTH = 4096,
	parameter int FRAC_BITS = 14
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_write,
	input  wire logic [CFG_INDEX_W-1:0]     cfg_index,
	input  wire logic [CFG_DATA_W-1:0]      cfg_data,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic signed [SAMPLE_W-1:0] sample,
	input  wire logic                       frame_start,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic signed [SAMPLE_W-1:0]      result,
	output logic      [PIX_W-1:0]           prediction
);

	localparam int COL_W = $clog2(MAX_WIDTH);

	logic                    direction_q;
	logic [LINE_WIDTH_W-1:0] line_width_q;
	weights_t                weights_q;

	logic                       valid_s1;
	logic                       valid_s2;
	logic                       out_valid_q;
	logic [COL_W-1:0]           col_s1;
	logic [COL_W-1:0]           col_s2;
	pos_t                       pos_s1;
	pos_t                       pos_s2;
	logic signed [SAMPLE_W-1:0] sample_s1;
	logic signed [SAMPLE_W-1:0] sample_s2;
	logic signed [SAMPLE_W-1:0] result_q;
	logic [PIX_W-1:0]           prediction_q;

	logic                       out_ready;
	logic                       s1_adv;
	logic                       s2_adv;
	logic                       accept;
	logic                       hazard;
	logic [COL_W-1:0]           col_in;
	logic [COL_W-1:0]           ur_addr;
	pos_t                       pos_in;
	logic [PIX_W-1:0]           up_data;
	logic [PIX_W-1:0]           ur_data;
	logic [PIX_W-1:0]           pix;
	logic signed [SAMPLE_W-1:0] res;
	logic [PIX_W-1:0]           pred;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q        <= DIR_ENCODE;
			line_width_q       <= LINE_WIDTH_RESET;
			weights_q.up_left  <= WEIGHT_RESET;
			weights_q.up       <= WEIGHT_RESET;
			weights_q.up_right <= WEIGHT_RESET;
			weights_q.left     <= WEIGHT_RESET;
		end else if (cfg_write) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_DIRECTION:       direction_q        <= cfg_data[0];
				REG_LINE_WIDTH:      line_width_q       <= cfg_data[LINE_WIDTH_W-1:0];
				REG_WEIGHT_UP_LEFT:  weights_q.up_left  <= $signed(cfg_data[WEIGHT_W-1:0]);
				REG_WEIGHT_UP:       weights_q.up       <= $signed(cfg_data[WEIGHT_W-1:0]);
				REG_WEIGHT_UP_RIGHT: weights_q.up_right <= $signed(cfg_data[WEIGHT_W-1:0]);
				REG_WEIGHT_LEFT:     weights_q.left     <= $signed(cfg_data[WEIGHT_W-1:0]);
				default: ;
			endcase
		end
	end

	// Pipeline handshake
	always_comb begin
		out_ready = !out_valid_q || !out_stall;
		s2_adv    = valid_s2 && out_ready;
		s1_adv    = valid_s1 && (!valid_s2 || s2_adv);
		in_stall  = (valid_s1 && !s1_adv) || hazard;
		accept    = in_valid && !in_stall;
	end

	clp_col #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_col (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.frame_start (frame_start),
		.line_width  (line_width_q),
		.pend1_valid (valid_s1),
		.pend1_col   (col_s1),
		.pend2_valid (valid_s2),
		.pend2_col   (col_s2),
		.col         (col_in),
		.ur_addr     (ur_addr),
		.pos         (pos_in),
		.hazard      (hazard)
	);

	// Line store copy read at the pixel's own column
	clp_ram #(
		.WIDTH(PIX_W),
		.DEPTH(MAX_WIDTH)
	) u_up_ram (
		.clk   (clk),
		.we    (s2_adv),
		.waddr (col_s2),
		.wdata (pix),
		.re    (accept),
		.raddr (col_in),
		.rdata (up_data)
	);

	// Line store copy read one column ahead
	clp_ram #(
		.WIDTH(PIX_W),
		.DEPTH(MAX_WIDTH)
	) u_ur_ram (
		.clk   (clk),
		.we    (s2_adv),
		.waddr (col_s2),
		.wdata (pix),
		.re    (accept),
		.raddr (ur_addr),
		.rdata (ur_data)
	);

	clp_dp #(
		.FRAC_BITS(FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.s1_adv    (s1_adv),
		.s2_adv    (s2_adv),
		.pos_s1    (pos_s1),
		.pos_s2    (pos_s2),
		.up_data   (up_data),
		.ur_data   (ur_data),
		.weights   (weights_q),
		.direction (direction_q),
		.sample_s2 (sample_s2),
		.pix       (pix),
		.res       (res),
		.pred      (pred)
	);

	// Stage valids and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				valid_s2 <= 1'b1;
			end else if (s2_adv) begin
				valid_s2 <= 1'b0;
			end
			if (s2_adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Advance the word payload
	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1    <= col_in;
			pos_s1    <= pos_in;
			sample_s1 <= sample;
		end
		if (s1_adv) begin
			col_s2    <= col_s1;
			pos_s2    <= pos_s1;
			sample_s2 <= sample_s1;
		end
		if (s2_adv) begin
			result_q     <= res;
			prediction_q <= pred;
		end
	end

	assign out_valid  = out_valid_q;
	assign result     = result_q;
	assign prediction = prediction_q;

endmodule

`default_nettype wire

[sim/tb_causal_linear_pixel_predictor.sv]
`default_nettype none

module tb_causal_linear_pixel_predictor;
	timeunit 1ns;
	timeprecision 1ps;
	import clp_pkg::*;

	localparam int MAX_W        = 4096;
	localparam int FRAC         = 14;
	localparam int RANDOM_ITEMS = 480;
	localparam int WIDE_ITEMS   = 40;
	localparam int HOLD_CYCLES  = 120;
	localparam int CYCLE_LIMIT  = 400000;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] value;
		logic                       sof;
	} pixel_word_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] result;
		logic [PIX_W-1:0]           prediction;
	} out_word_t;

	logic                       clk         = 1'b0;
	logic                       arst_n      = 1'b0;
	logic                       cfg_write   = 1'b0;
	logic [CFG_INDEX_W-1:0]     cfg_index   = REG_DIRECTION;
	logic [CFG_DATA_W-1:0]      cfg_data    = '0;
	logic                       in_valid    = 1'b0;
	logic                       in_stall;
	logic signed [SAMPLE_W-1:0] sample      = '0;
	logic                       frame_start = 1'b0;
	logic                       out_valid;
	logic                       out_stall   = 1'b0;
	logic signed [SAMPLE_W-1:0] result;
	logic [PIX_W-1:0]           prediction;

	causal_linear_pixel_predictor dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.sample     (sample),
		.frame_start(frame_start),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.result     (result),
		.prediction (prediction)
	);

	always #5 clk = ~clk;

	// Predictor copy of the registers
	logic                       cfg_dir   = DIR_ENCODE;
	logic [LINE_WIDTH_W-1:0]    cfg_width = LINE_WIDTH_RESET;
	logic signed [WEIGHT_W-1:0] w_ul      = WEIGHT_RESET;
	logic signed [WEIGHT_W-1:0] w_u       = WEIGHT_RESET;
	logic signed [WEIGHT_W-1:0] w_ur      = WEIGHT_RESET;
	logic signed [WEIGHT_W-1:0] w_l       = WEIGHT_RESET;

	// Predictor copy of the raster state
	logic [PIX_W-1:0] row_mem [0:MAX_W-1];
	logic [PIX_W-1:0] left_px    = '0;
	logic [PIX_W-1:0] up_left_px = '0;
	int               col_cnt    = 0;
	logic             first_row  = 1'b1;

	pixel_word_t pending_words [$];
	out_word_t   predicted_words [$];
	logic [CFG_DATA_W-1:0] cfg_next [6];

	int   words_queued     = 0;
	int   words_taken      = 0;
	int   errors           = 0;
	int   hold_requests    = 0;
	int   holds_done       = 0;
	int   hold_left        = 0;
	int   stall_left       = 0;
	int   gap_left         = 0;
	int   cycles           = 0;
	int   scene_px         = 128;
	logic send_idle        = 1'b1;
	logic recv_idle        = 1'b1;
	logic start_frame_next = 1'b0;

	function automatic int eff_width(logic [LINE_WIDTH_W-1:0] lw);
		if (lw == 0) return 1;
		if (lw > MAX_W) return MAX_W;
		return lw;
	endfunction

	// Predict one pixel word and advance the raster state
	function automatic out_word_t predict_pixel(logic signed [SAMPLE_W-1:0] s, logic sof);
		int         w;
		int         c;
		int         smp;
		int         pred;
		int         pix;
		int         res;
		longint     n_ul;
		longint     n_u;
		longint     n_ur;
		longint     n_l;
		longint     acc;
		logic [7:0] above;
		out_word_t  o;
		w = eff_width(cfg_width);
		smp = s;
		if (sof) begin
			col_cnt = 0;
			first_row = 1'b1;
		end
		c = (col_cnt >= MAX_W) ? MAX_W - 1 : col_cnt;
		above = row_mem[c];
		n_u = first_row ? 0 : above;
		n_ul = (first_row || c == 0) ? 0 : up_left_px;
		n_l = (c == 0) ? 0 : left_px;
		n_ur = 0;
		if (!first_row && c + 1 < w)
			n_ur = row_mem[c + 1];
		acc = n_ul * longint'(w_ul) + n_u * longint'(w_u)
			+ n_ur * longint'(w_ur) + n_l * longint'(w_l);
		// round half away from zero, clamp to a pixel
		if (acc <= 0) begin
			pred = 0;
		end else begin
			acc = (acc + (longint'(1) << (FRAC - 1))) >>> FRAC;
			pred = (acc > 255) ? 255 : int'(acc);
		end
		if (cfg_dir == DIR_ENCODE) begin
			pix = (smp < 0) ? 0 : smp;
			res = pix - pred;
		end else begin
			pix = pred + smp;
			if (pix < 0) pix = 0;
			if (pix > 255) pix = 255;
			res = pix;
		end
		row_mem[c] = pix[7:0];
		up_left_px = above;
		left_px = pix[7:0];
		if (c + 1 >= w) begin
			col_cnt = 0;
			first_row = 1'b0;
		end else begin
			col_cnt = c + 1;
		end
		o.result = res[SAMPLE_W-1:0];
		o.prediction = pred[PIX_W-1:0];
		return o;
	endfunction

	// Smooth image content with occasional arbitrary codes
	function automatic logic signed [SAMPLE_W-1:0] draw_sample(logic dir);
		int v;
		case ($urandom_range(0, 9))
		0: v = int'($urandom_range(0, 511)) - 256;
		1: v = $urandom_range(0, 1) ? 255 : 0;
		default: begin
			if (dir == DIR_ENCODE) begin
				scene_px = scene_px + int'($urandom_range(0, 30)) - 15;
				if (scene_px < 0) scene_px = 0;
				if (scene_px > 255) scene_px = 255;
				v = scene_px;
			end else begin
				v = int'($urandom_range(0, 16)) - 8;
			end
		end
		endcase
		return v[SAMPLE_W-1:0];
	endfunction

	task automatic push_word(logic signed [SAMPLE_W-1:0] v, logic sof);
		pixel_word_t wd;
		wd.value = v;
		wd.sof = sof | start_frame_next;
		start_frame_next = 1'b0;
		pending_words.push_back(wd);
		words_queued++;
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
		int old_w;
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
		REG_DIRECTION: cfg_dir = val[0];
		REG_LINE_WIDTH: begin
			// a wider row would read line store entries not yet written
			old_w = eff_width(cfg_width);
			cfg_width = val[LINE_WIDTH_W-1:0];
			if (eff_width(cfg_width) > old_w)
				start_frame_next = 1'b1;
		end
		REG_WEIGHT_UP_LEFT: w_ul = val;
		REG_WEIGHT_UP: w_u = val;
		REG_WEIGHT_UP_RIGHT: w_ur = val;
		REG_WEIGHT_LEFT: w_l = val;
		default: ;
		endcase
	endtask

	task automatic apply_config(logic [5:0] which);
		for (int i = 0; i < 6; i++)
			if (which[i])
				write_reg(cfg_reg_t'(i), cfg_next[i]);
		cfg_write <= 1'b0;
	endtask

	task automatic wait_idle();
		while (words_taken != words_queued || predicted_words.size() != 0)
			@(posedge clk);
	endtask

	// Driver: offer pending words, hold while stalled
	always @(posedge clk or negedge arst_n) begin : driver
		pixel_word_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
			sample <= '0;
			frame_start <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				predicted_words.push_back(predict_pixel(sample, frame_start));
				words_taken++;
			end
			if (!(in_valid && in_stall)) begin
				if (gap_left > 0) begin
					in_valid <= 1'b0;
					gap_left--;
				end else if (pending_words.size() != 0) begin
					nxt = pending_words.pop_front();
					sample <= nxt.value;
					frame_start <= nxt.sof;
					in_valid <= 1'b1;
					gap_left = send_idle ? $urandom_range(0, 4) : 0;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each result word, drive stall
	always @(posedge clk or negedge arst_n) begin : monitor
		out_word_t exp_word;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (predicted_words.size() == 0) begin
					if (errors < 10)
						$display("unexpected word: result %0d prediction %0d", result, prediction);
					errors++;
				end else begin
					exp_word = predicted_words.pop_front();
					if (result !== exp_word.result || prediction !== exp_word.prediction) begin
						if (errors < 10)
							$display("mismatch: result %0d prediction %0d, expected %0d %0d",
								result, prediction, exp_word.result, exp_word.prediction);
						errors++;
					end
				end
				stall_left = recv_idle ? $urandom_range(0, 4) : 0;
			end
			// long hold-off first, then per-word stalls
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (holds_done != hold_requests) begin
				holds_done++;
				hold_left = HOLD_CYCLES - 1;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAIL causal_linear_pixel_predictor");
			$finish;
		end
	end

	initial begin : stimulus
		int          n;
		int          k;
		int          wsel;
		int          phase_len;
		int          phase_no;
		int          wts [4];
		logic [31:0] junk;
		logic        sof;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// encode, four-pixel rows: extremes, negative pixels, edges
		cfg_next[REG_DIRECTION] = DIR_ENCODE;
		cfg_next[REG_LINE_WIDTH] = 18'd4;
		apply_config(6'b000011);
		push_word(255, 1'b1);
		push_word(0, 1'b0);
		push_word(-256, 1'b0);
		push_word(-1, 1'b0);
		push_word(255, 1'b0);
		push_word(255, 1'b0);
		push_word(128, 1'b0);
		push_word(1, 1'b0);
		push_word(200, 1'b0);
		push_word(7, 1'b0);
		push_word(255, 1'b0);
		push_word(0, 1'b0);

		// decode, zero width acts as a one-pixel row
		wait_idle();
		cfg_next[REG_DIRECTION] = DIR_DECODE;
		cfg_next[REG_LINE_WIDTH] = 18'd0;
		apply_config(6'b000011);
		push_word(255, 1'b1);
		push_word(-256, 1'b0);
		push_word(100, 1'b0);
		push_word(-100, 1'b0);
		push_word(255, 1'b0);

		// extreme weights: negative sums and saturation
		wait_idle();
		cfg_next[REG_DIRECTION] = DIR_ENCODE;
		cfg_next[REG_LINE_WIDTH] = 18'd2;
		cfg_next[REG_WEIGHT_UP_LEFT] = 18'h20000;
		cfg_next[REG_WEIGHT_UP] = 18'h20000;
		cfg_next[REG_WEIGHT_UP_RIGHT] = 18'h1FFFF;
		cfg_next[REG_WEIGHT_LEFT] = 18'h1FFFF;
		apply_config(6'b111111);
		push_word(255, 1'b1);
		push_word(0, 1'b0);
		push_word(255, 1'b0);
		push_word(255, 1'b0);
		push_word(0, 1'b0);
		push_word(255, 1'b0);

		// oversized width acts as a full row; no idling here
		wait_idle();
		send_idle = 1'b0;
		recv_idle = 1'b0;
		cfg_next[REG_LINE_WIDTH] = 18'd8191;
		cfg_next[REG_WEIGHT_UP_LEFT] = 18'd4096;
		cfg_next[REG_WEIGHT_UP] = 18'd4096;
		cfg_next[REG_WEIGHT_UP_RIGHT] = 18'd4096;
		cfg_next[REG_WEIGHT_LEFT] = 18'd4096;
		apply_config(6'b111110);
		for (k = 0; k < WIDE_ITEMS; k++)
			push_word(draw_sample(DIR_ENCODE), 1'b0);

		// random phases of settings and pixel words
		n = 0;
		phase_no = 0;
		while (n < RANDOM_ITEMS) begin
			wait_idle();
			junk = $urandom;
			cfg_next[REG_DIRECTION] = {junk[17:1], 1'($urandom_range(0, 1))};
			case ($urandom_range(0, 9))
			0: wsel = 0;
			1: wsel = 1;
			2: wsel = 2;
			3: wsel = 3;
			4: wsel = $urandom_range(MAX_W + 1, 8191);
			5: wsel = MAX_W;
			default: wsel = $urandom_range(4, 40);
			endcase
			cfg_next[REG_LINE_WIDTH] = {junk[31:27], wsel[LINE_WIDTH_W-1:0]};
			case ($urandom_range(0, 3))
			0: for (k = 0; k < 4; k++) wts[k] = 4096;
			1: begin
				// roughly normalized to one
				wts[3] = 16384;
				for (k = 0; k < 3; k++) begin
					wts[k] = int'($urandom_range(0, 24576)) - 8192;
					wts[3] -= wts[k];
				end
				if (wts[3] > 131071) wts[3] = 131071;
				if (wts[3] < -131072) wts[3] = -131072;
			end
			2: for (k = 0; k < 4; k++) wts[k] = $urandom_range(0, 262143);
			default: begin
				for (k = 0; k < 4; k++)
					case ($urandom_range(0, 3))
					0: wts[k] = -131072;
					1: wts[k] = 131071;
					2: wts[k] = 0;
					default: wts[k] = 16384;
					endcase
			end
			endcase
			for (k = 0; k < 4; k++)
				cfg_next[2 + k] = wts[k][CFG_DATA_W-1:0];
			apply_config(6'($urandom_range(1, 63)));
			send_idle = ($urandom_range(0, 3) != 0);
			recv_idle = ($urandom_range(0, 3) != 0);
			if (phase_no % 7 == 0)
				hold_requests++;
			phase_len = $urandom_range(20, 70);
			for (k = 0; k < phase_len; k++) begin
				sof = (k == 0 && $urandom_range(0, 1) == 1) || $urandom_range(0, 39) == 0;
				push_word(draw_sample(cfg_dir), sof);
			end
			n += phase_len;
			phase_no++;
		end

		wait_idle();
		repeat (8) @(posedge clk);
		if (errors == 0 && predicted_words.size() == 0) begin
			$display("PASS causal_linear_pixel_predictor");
		end else begin
			$display("FAIL causal_linear_pixel_predictor");
		end
		$finish;
	end

endmodule

`default_nettype wire
